>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the HSL shift block.
// Needs no other file; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/rhsl_pkg.sv
// Shared types, constants and the divider step of the HSL shift block.
// Used by the front, queue, back and top-level modules.
package rhsl_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int CFG_W       = 14;
  localparam int DIV_STAGES  = 25;          // quotient bits per divider lane
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int HUE_FULL    = 360 * ONE;
  // floor(x / 15) = (x * HUE_RECIP) >> 28 for x below 2^22.
  localparam logic [24:0] HUE_RECIP = 25'd17895698;
  // floor(x * ONE / 510) = (x * LIGHT_RECIP) >> 17 for x up to 510.
  localparam logic [24:0] LIGHT_RECIP = 25'd16843010;

  typedef enum logic [1:0] {
    CFG_HUE   = 2'd0,
    CFG_SAT   = 2'd1,
    CFG_LIGHT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEL_UP,
    SEL_T1,
    SEL_DOWN,
    SEL_T2
  } chan_sel_e;

  typedef struct packed {
    logic [8:0]  sum;    // max + min
    logic [7:0]  d;      // max - min
    logic [16:0] num;    // hue numerator
    logic [7:0]  sden;   // saturation denominator
    logic        gray;
    logic        last;
  } px_item_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QPTR_W:0]   count;
  } q_status_t;

  // One restoring division step: returns {remainder, shifted dividend/quotient}.
  function automatic logic [34:0] div_step(input logic [9:0] rem,
                                           input logic [24:0] low,
                                           input logic [8:0] dvs);
    logic [9:0] r2;
    logic       qb;
    r2 = {rem[8:0], low[24]};
    qb = (r2 >= {1'b0, dvs});
    if (qb) r2 = r2 - {1'b0, dvs};
    return {r2, low[23:0], qb};
  endfunction

endpackage

>>> sv/rhsl_front.sv
// Front end: accepts RGB pixels and classifies them into HSL divider operands.
// Depends on rhsl_pkg.
module rhsl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic [23:0]         s_tdata_i,
  input  logic                s_tlast_i,
  output logic                s_tready_o,
  input  logic                q_full_i,
  output logic                item_valid_o,
  output rhsl_pkg::px_item_t  item_o
);

  logic               valid_q;
  rhsl_pkg::px_item_t item_q, item_d;
  logic [7:0]         r, g, b, mx, mn, d;
  logic [8:0]         sum;
  logic [10:0]        k;
  logic               take;

  assign s_tready_o   = !valid_q || !q_full_i;
  assign take         = s_tvalid_i && s_tready_o;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_comb begin
    r = s_tdata_i[7:0];
    g = s_tdata_i[15:8];
    b = s_tdata_i[23:16];
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    // Sector offset in units of d; every branch ends non-negative.
    if (mx == r) begin
      if (g >= b) k = {3'b0, g} - {3'b0, b};
      else k = ({3'b0, d} * 11'd6) + {3'b0, g} - {3'b0, b};
    end else if (mx == g) begin
      k = {2'b0, d, 1'b0} + {3'b0, b} - {3'b0, r};
    end else begin
      k = {1'b0, d, 2'b0} + {3'b0, r} - {3'b0, g};
    end
    item_d.sum  = sum;
    item_d.d    = d;
    item_d.num  = {k, 6'b0} - {4'b0, k, 2'b0};
    item_d.sden = (sum > 9'd255) ? 8'(9'd510 - sum) : sum[7:0];
    item_d.gray = (d == 8'd0);
    item_d.last = s_tlast_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_tready_o) begin
      valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) item_q <= item_d;
  end

endmodule

>>> sv/rhsl_queue.sv
// Small FIFO that decouples the classifying front end from the back end.
// Depends on rhsl_pkg.
module rhsl_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rhsl_pkg::px_item_t   item_i,
  input  logic                 pop_i,
  output rhsl_pkg::px_item_t   item_o,
  output rhsl_pkg::q_status_t  status_o
);

  rhsl_pkg::px_item_t              mem_q [rhsl_pkg::QUEUE_DEPTH];
  logic [rhsl_pkg::QPTR_W-1:0]     wr_q, rd_q;
  logic [rhsl_pkg::QPTR_W:0]       cnt_q;

  assign item_o          = mem_q[rd_q];
  assign status_o.count  = cnt_q;
  assign status_o.empty  = (cnt_q == '0);
  assign status_o.full   = (cnt_q == (rhsl_pkg::QPTR_W+1)'(rhsl_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

>>> sv/rhsl_back.sv
// Back end: pipelined dividers, HSL shift and the HSL-to-RGB conversion.
// Depends on rhsl_pkg; fed by rhsl_queue.
module rhsl_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rhsl_pkg::px_item_t          item_i,
  input  rhsl_pkg::q_status_t         q_status_i,
  output logic                        pop_o,
  input  logic signed [13:0]          hue_off_i,
  input  logic signed [13:0]          sat_off_i,
  input  logic signed [13:0]          light_off_i,
  input  logic                        m_tready_i,
  output logic                        m_tvalid_o,
  output logic [23:0]                 m_tdata_o,
  output logic                        m_tlast_o
);

  localparam int NS = rhsl_pkg::DIV_STAGES;
  localparam logic [16:0] ONE17  = 17'(rhsl_pkg::ONE);
  localparam logic [16:0] HALF17 = 17'(rhsl_pkg::ONE / 2);
  localparam logic [18:0] ONE19  = 19'(rhsl_pkg::ONE);
  localparam logic [18:0] HALF19 = 19'(rhsl_pkg::ONE / 2);
  localparam logic [18:0] THREE_HALF19 = 19'(3 * rhsl_pkg::ONE / 2);
  localparam logic [18:0] TWO19  = 19'(2 * rhsl_pkg::ONE);
  localparam logic [18:0] THREE19 = 19'(3 * rhsl_pkg::ONE);
  localparam logic signed [26:0] HFULL = 27'(rhsl_pkg::HUE_FULL);

  logic en;

  // Divider pipeline: two lanes (hue, saturation); lightness comes from a
  // reciprocal product and travels alongside.
  logic        dv_q   [0:NS];
  logic [9:0]  hrem_q [0:NS];
  logic [24:0] hlow_q [0:NS];
  logic [9:0]  srem_q [0:NS];
  logic [24:0] slow_q [0:NS];
  logic [16:0] l_q    [0:NS];
  logic [7:0]  hd_q   [0:NS];
  logic [7:0]  sd_q   [0:NS];
  logic        gray_q [0:NS];
  logic        last_q [0:NS];
  logic [33:0] l_prod;

  logic [5:0]  evld_q;

  logic [24:0] e1_h_q;
  logic [16:0] e1_s_q, e1_l_q;
  logic        e1_last_q;

  logic [46:0] e2_hp_q;
  logic [33:0] e2_ls_q;
  logic [16:0] e2_s_q, e2_l_q;
  logic        e2_last_q;

  logic [17:0]        e3_t_q;
  logic signed [19:0] e3_t1_q, e3_t2_q;
  logic               e3_last_q;

  rhsl_pkg::chan_sel_e e4_sel_q [3];
  logic [16:0]         e4_f_q   [3];
  logic signed [19:0]  e4_t1_q, e4_t2_q;
  logic                e4_last_q;

  rhsl_pkg::chan_sel_e e5_sel_q  [3];
  logic signed [37:0]  e5_prod_q [3];
  logic signed [19:0]  e5_t1_q, e5_t2_q;
  logic                e5_last_q;

  logic [7:0] out_q [3];
  logic       out_last_q;

  assign en    = !evld_q[5] || m_tready_i;
  assign pop_o = en && !q_status_i.empty;

  assign m_tvalid_o = evld_q[5];
  assign m_tdata_o  = {out_q[2], out_q[1], out_q[0]};
  assign m_tlast_o  = out_last_q;

  // Lightness is (max + min) * ONE / 510, taken from bits 33..17 of the product.
  assign l_prod = 34'(item_i.sum) * 34'(rhsl_pkg::LIGHT_RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NS; i++) dv_q[i] <= 1'b0;
      evld_q <= '0;
    end else if (en) begin
      dv_q[0] <= !q_status_i.empty;
      for (int i = 1; i <= NS; i++) dv_q[i] <= dv_q[i-1];
      evld_q <= {evld_q[4:0], dv_q[NS]};
    end
  end

  // Division lanes.
  always_ff @(posedge clk_i) begin
    if (en) begin
      hrem_q[0] <= {2'b0, item_i.num[16:9]};
      hlow_q[0] <= {item_i.num[8:0], {rhsl_pkg::FRAC_BITS{1'b0}}};
      srem_q[0] <= '0;
      slow_q[0] <= {1'b0, item_i.d, {rhsl_pkg::FRAC_BITS{1'b0}}};
      l_q[0]    <= l_prod[33:17];
      hd_q[0]   <= item_i.d;
      sd_q[0]   <= item_i.sden;
      gray_q[0] <= item_i.gray;
      last_q[0] <= item_i.last;
      for (int i = 1; i <= NS; i++) begin
        {hrem_q[i], hlow_q[i]} <= rhsl_pkg::div_step(hrem_q[i-1], hlow_q[i-1],
                                                     {1'b0, hd_q[i-1]});
        {srem_q[i], slow_q[i]} <= rhsl_pkg::div_step(srem_q[i-1], slow_q[i-1],
                                                     {1'b0, sd_q[i-1]});
        l_q[i]    <= l_q[i-1];
        hd_q[i]   <= hd_q[i-1];
        sd_q[i]   <= sd_q[i-1];
        gray_q[i] <= gray_q[i-1];
        last_q[i] <= last_q[i-1];
      end
    end
  end

  // E1: hue wrap and saturation / lightness shift with clamping.
  logic signed [26:0] hw0, hw1, hw2;
  logic signed [19:0] s20, l20;
  logic [16:0]        e1_s_d, e1_l_d;

  always_comb begin
    hw0 = $signed({2'b0, (gray_q[NS] ? 25'd0 : hlow_q[NS])})
        + ($signed({{13{hue_off_i[13]}}, hue_off_i}) <<< 12);
    if (hw0 > HFULL)               hw1 = hw0 - HFULL;
    else if (hw0 < 27'sd0)         hw1 = hw0 + HFULL;
    else                           hw1 = hw0;
    if (hw1 > HFULL)               hw2 = hw1 - HFULL;
    else if (hw1 < 27'sd0)         hw2 = hw1 + HFULL;
    else                           hw2 = hw1;
    s20 = $signed({3'b0, (gray_q[NS] ? 17'd0 : slow_q[NS][16:0])})
        + $signed({{2{sat_off_i[13]}}, sat_off_i, 4'b0});
    l20 = $signed({3'b0, l_q[NS]})
        + $signed({{2{light_off_i[13]}}, light_off_i, 4'b0});
    if (s20 < 20'sd0)                       e1_s_d = '0;
    else if (s20 > $signed({3'b0, ONE17}))  e1_s_d = ONE17;
    else                                    e1_s_d = s20[16:0];
    if (l20 < 20'sd0)                       e1_l_d = '0;
    else if (l20 > $signed({3'b0, ONE17}))  e1_l_d = ONE17;
    else                                    e1_l_d = l20[16:0];
  end

  // E3: the two HSL helper terms.
  logic signed [19:0] l_s20, s_s20, lsh20, t1_d;

  always_comb begin
    l_s20 = $signed({3'b0, e2_l_q});
    s_s20 = $signed({3'b0, e2_s_q});
    lsh20 = $signed({2'b0, e2_ls_q[33:16]});
    if (e2_l_q < HALF17) t1_d = l_s20 + lsh20;
    else                 t1_d = l_s20 + s_s20 - lsh20;
  end

  // E4: per-channel hue position and ramp selection.
  logic [18:0]         pos   [3];
  logic [18:0]         t19, tr;
  rhsl_pkg::chan_sel_e sel_d [3];
  logic [16:0]         f_d   [3];

  always_comb begin
    t19 = {1'b0, e3_t_q};
    tr  = t19 + ONE19;
    if (tr > THREE19) tr = tr - THREE19;
    pos[0] = tr;
    pos[1] = t19;
    pos[2] = (t19 < ONE19) ? (t19 + TWO19) : (t19 - ONE19);
    for (int c = 0; c < 3; c++) begin
      if (pos[c] < HALF19) begin
        sel_d[c] = rhsl_pkg::SEL_UP;
        f_d[c]   = {pos[c][15:0], 1'b0};
      end else if (pos[c] < THREE_HALF19) begin
        sel_d[c] = rhsl_pkg::SEL_T1;
        f_d[c]   = '0;
      end else if (pos[c] < TWO19) begin
        sel_d[c] = rhsl_pkg::SEL_DOWN;
        f_d[c]   = 17'({TWO19 - pos[c], 1'b0});
      end else begin
        sel_d[c] = rhsl_pkg::SEL_T2;
        f_d[c]   = '0;
      end
    end
  end

  // E6: channel value, clamp and scale to 8 bits.
  logic signed [21:0] v     [3];
  logic [16:0]        vc    [3];
  logic [24:0]        y     [3];
  logic [7:0]         out_d [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      unique case (e5_sel_q[c])
        rhsl_pkg::SEL_T1: v[c] = {{2{e5_t1_q[19]}}, e5_t1_q};
        rhsl_pkg::SEL_T2: v[c] = {{2{e5_t2_q[19]}}, e5_t2_q};
        default:          v[c] = {{2{e5_t2_q[19]}}, e5_t2_q} + $signed(e5_prod_q[c][37:16]);
      endcase
      if (v[c] < 22'sd0)                       vc[c] = '0;
      else if (v[c] > $signed({5'b0, ONE17}))  vc[c] = ONE17;
      else                                     vc[c] = v[c][16:0];
      y[c]     = {vc[c], 8'b0} - {8'b0, vc[c]};
      out_d[c] = y[c][23:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_h_q    <= hw2[24:0];
      e1_s_q    <= e1_s_d;
      e1_l_q    <= e1_l_d;
      e1_last_q <= last_q[NS];

      e2_hp_q   <= 47'(e1_h_q[24:3]) * 47'(rhsl_pkg::HUE_RECIP);
      e2_ls_q   <= 34'(e1_l_q) * 34'(e1_s_q);
      e2_l_q    <= e1_l_q;
      e2_s_q    <= e1_s_q;
      e2_last_q <= e1_last_q;

      e3_t_q    <= e2_hp_q[45:28];
      e3_t1_q   <= t1_d;
      e3_t2_q   <= (l_s20 <<< 1) - t1_d;
      e3_last_q <= e2_last_q;

      for (int c = 0; c < 3; c++) begin
        e4_sel_q[c]  <= sel_d[c];
        e4_f_q[c]    <= f_d[c];
        e5_sel_q[c]  <= e4_sel_q[c];
        e5_prod_q[c] <= 38'(e4_t1_q - e4_t2_q) * $signed({21'b0, e4_f_q[c]});
        out_q[c]     <= out_d[c];
      end
      e4_t1_q    <= e3_t1_q;
      e4_t2_q    <= e3_t2_q;
      e4_last_q  <= e3_last_q;
      e5_t1_q    <= e4_t1_q;
      e5_t2_q    <= e4_t2_q;
      e5_last_q  <= e4_last_q;
      out_last_q <= e5_last_q;
    end
  end

endmodule

>>> sv/rgb_hsl_shift_pixel_top.sv
// Top level of the RGB pixel HSL shift block: configuration registers,
// front end, decoupling queue and back-end pipeline. Depends on rhsl_pkg.
//
// Usage: pixels enter on the s_axis channel (tdata = red, green, blue from
// bit 0 up, tlast = last pixel of a frame) and leave on the m_axis channel
// in the same order and packing, tlast copied through.
// Hue, saturation and lightness shifts are written through cfg_we_i,
// cfg_idx_i and cfg_data_i while no pixel is in flight.
// Throughput is one pixel per clock while the receiver does not stall. From
// input transaction to output valid, a pixel passes the front register, the
// queue, the 25-step pipelined restoring dividers that form hue and
// saturation, and the shift and conversion stages.
// Reset clears the shifts to zero and empties all pipeline stages.
// When the receiver stalls, the back-end pipeline holds; the front end keeps
// taking pixels until its four-entry queue and its register are full, and
// only then drops s_axis_tready_o.
`include "assert_macros.svh"

module rgb_hsl_shift_pixel_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // red_in, green_in, blue_in
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // red_out, green_out, blue_out
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [13:0] cfg_data_i
);

  logic signed [13:0]  hue_off_q, sat_off_q, light_off_q;
  logic                front_vld, push, pop;
  rhsl_pkg::px_item_t  front_item, q_item;
  rhsl_pkg::q_status_t q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_off_q   <= '0;
      sat_off_q   <= '0;
      light_off_q <= '0;
    end else if (cfg_we_i) begin
      unique case (rhsl_pkg::cfg_idx_e'(cfg_idx_i))
        rhsl_pkg::CFG_HUE:   hue_off_q   <= cfg_data_i;
        rhsl_pkg::CFG_SAT:   sat_off_q   <= cfg_data_i;
        rhsl_pkg::CFG_LIGHT: light_off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign push = front_vld && !q_stat.full;

  rhsl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tdata_i    (s_axis_tdata_i),
    .s_tlast_i    (s_axis_tlast_i),
    .s_tready_o   (s_axis_tready_o),
    .q_full_i     (q_stat.full),
    .item_valid_o (front_vld),
    .item_o       (front_item)
  );

  rhsl_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (q_item),
    .status_o (q_stat)
  );

  rhsl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (q_item),
    .q_status_i  (q_stat),
    .pop_o       (pop),
    .hue_off_i   (hue_off_q),
    .sat_off_i   (sat_off_q),
    .light_off_i (light_off_q),
    .m_tready_i  (m_axis_tready_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tlast_o   (m_axis_tlast_o)
  );

  // The input only stalls when the front register and the queue are both full.
  `ASSERT_IMPLIES(a_stall_cause, clk_i, rst_ni, !s_axis_tready_o, front_vld && q_stat.full)
  // The back end never pops an empty queue.
  `ASSERT_IMPLIES(a_pop_nonempty, clk_i, rst_ni, pop, !q_stat.empty)
  // A push into a queue with room and no pop raises the fill count by one.
  `ASSERT_NEXT(a_push_count, clk_i, rst_ni, push && !pop, q_stat.count == $past(q_stat.count) + 3'd1)
endmodule
